/* rtl/nss_pkg.sv */
`default_nettype none

package nss_pkg;

  // Default sizes
  localparam int unsigned MAX_STATES_DEF = 64;
  localparam int unsigned MAX_EDGES_DEF  = 256;

  // Field widths
  localparam int unsigned STATE_W = 6;
  localparam int unsigned SYM_W   = 8;
  localparam int unsigned MASK_W  = 64;
  localparam int unsigned EDGE_W  = 2 * STATE_W + SYM_W;

  // Packed edge word: {source, target, symbol}
  localparam int unsigned EDGE_SYM_LSB = 0;
  localparam int unsigned EDGE_DST_LSB = SYM_W;
  localparam int unsigned EDGE_SRC_LSB = SYM_W + STATE_W;

  localparam logic [STATE_W-1:0] START_RESET = 6'd1;

  typedef enum logic [1:0] {
    ACT_LOAD    = 2'd0,
    ACT_FINAL   = 2'd1,
    ACT_CONSUME = 2'd2,
    ACT_END     = 2'd3
  } action_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_HOLD
  } ctrl_state_t;

  // Request from control to the scan engine
  typedef struct packed {
    logic              start;
    logic [SYM_W-1:0]  sym;
    logic [MASK_W-1:0] cur_mask;
  } scan_req_t;

  // Result from the scan engine
  typedef struct packed {
    logic              done;
    logic [MASK_W-1:0] next_mask;
  } scan_rsp_t;

  // One-hot bit of a state, empty when the state is out of range
  function automatic logic [MASK_W-1:0] state_bit(input logic [STATE_W-1:0] s,
                                                  input int unsigned nstates);
    logic [MASK_W-1:0] b;
    b = {{(MASK_W-1){1'b0}}, 1'b1} << s;
    if (32'(s) >= nstates) begin
      b = '0;
    end
    return b;
  endfunction

endpackage

`default_nettype wire

/* rtl/nfa_symbol_stepper_top.sv */
`default_nettype none

// NFA stepper: load edges (source, symbol, target) and final states, then feed
// a word one symbol per item; every item returns exactly one result with the
// active state set, and an end-of-word item also reports acceptance and makes
// start_state the only active state again. Edge loads, final marks and end of
// word are answered without a sweep. A consumed symbol sweeps the edge memory
// through its single read port, one edge per cycle; when no edge is stored the
// set empties without a sweep. Edges are kept in a MAX_EDGES deep memory that
// needs no clearing: only entries below the fill count are read. Writes to
// start_state take effect at the next end of word.

module nfa_symbol_stepper_top #(
  parameter int unsigned MAX_STATES = nss_pkg::MAX_STATES_DEF,
  parameter int unsigned MAX_EDGES  = nss_pkg::MAX_EDGES_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          cfg_wr_en,
  input  wire logic [nss_pkg::STATE_W-1:0]   cfg_wr_data,
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire logic [1:0]                    action,
  input  wire logic [nss_pkg::STATE_W-1:0]   source_state,
  input  wire logic [nss_pkg::STATE_W-1:0]   target_state,
  input  wire logic [nss_pkg::SYM_W-1:0]     symbol,
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output logic [nss_pkg::MASK_W-1:0]         active_mask,
  output logic                               accepted,
  output logic                               table_full
);

  localparam int unsigned AW = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
  localparam int unsigned CW = $clog2(MAX_EDGES + 1);

  nss_pkg::ctrl_state_t        state, state_next;
  nss_pkg::action_t            act;
  nss_pkg::scan_req_t          scan_req;
  nss_pkg::scan_rsp_t          scan_rsp;

  logic [nss_pkg::STATE_W-1:0] start_state;
  logic [CW-1:0]               edge_count;
  logic [nss_pkg::MASK_W-1:0]  final_mask;
  logic [nss_pkg::MASK_W-1:0]  current_mask;

  logic [nss_pkg::MASK_W-1:0]  hold_mask;
  logic                        hold_acc;
  logic                        hold_full;

  logic                        acc_in;
  logic                        out_free;
  logic                        count_nz;
  logic                        table_is_full;
  logic                        start_scan;
  logic                        mem_we;
  logic [AW-1:0]               mem_raddr;
  logic                        mem_re;
  logic [nss_pkg::EDGE_W-1:0]  mem_rdata;

  logic                        imm_valid;
  logic [nss_pkg::MASK_W-1:0]  imm_mask;
  logic                        imm_acc;
  logic                        imm_full;
  logic [nss_pkg::MASK_W-1:0]  current_mask_next;
  logic [nss_pkg::MASK_W-1:0]  final_mask_next;

  logic                        res_valid;
  logic [nss_pkg::MASK_W-1:0]  res_mask;
  logic                        res_acc;
  logic                        res_full;

  assign act           = nss_pkg::action_t'(action);
  assign acc_in        = in_valid && !in_stall;
  assign out_free      = !out_valid || !out_stall;
  assign count_nz      = edge_count != '0;
  assign table_is_full = edge_count == CW'(MAX_EDGES);

  // Effect of an item accepted in idle
  always_comb begin
    imm_valid         = 1'b0;
    imm_mask          = current_mask;
    imm_acc           = 1'b0;
    imm_full          = 1'b0;
    mem_we            = 1'b0;
    current_mask_next = current_mask;
    final_mask_next   = final_mask;
    if (acc_in) begin
      unique case (act)
        nss_pkg::ACT_LOAD: begin
          imm_valid = 1'b1;
          imm_full  = table_is_full;
          mem_we    = !table_is_full;
        end
        nss_pkg::ACT_FINAL: begin
          imm_valid       = 1'b1;
          final_mask_next = final_mask | nss_pkg::state_bit(source_state, MAX_STATES);
        end
        nss_pkg::ACT_CONSUME: begin
          // no edges: the set empties at once
          imm_valid = !count_nz;
          imm_mask  = '0;
          if (!count_nz) begin
            current_mask_next = '0;
          end
        end
        nss_pkg::ACT_END: begin
          imm_valid         = 1'b1;
          imm_acc           = (current_mask & final_mask) != '0;
          imm_mask          = nss_pkg::state_bit(start_state, MAX_STATES);
          current_mask_next = imm_mask;
        end
        default: ;
      endcase
    end
  end

  // Result source: immediate, scan finish, or held result
  always_comb begin
    res_valid = 1'b0;
    res_mask  = imm_mask;
    res_acc   = imm_acc;
    res_full  = imm_full;
    unique case (state)
      nss_pkg::ST_IDLE: begin
        res_valid = imm_valid;
      end
      nss_pkg::ST_SCAN: begin
        res_valid = scan_rsp.done;
        res_mask  = scan_rsp.next_mask;
        res_acc   = 1'b0;
        res_full  = 1'b0;
      end
      nss_pkg::ST_HOLD: begin
        res_valid = 1'b1;
        res_mask  = hold_mask;
        res_acc   = hold_acc;
        res_full  = hold_full;
      end
      default: ;
    endcase
  end

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      nss_pkg::ST_IDLE: begin
        if (start_scan) begin
          state_next = nss_pkg::ST_SCAN;
        end else if (res_valid && !out_free) begin
          state_next = nss_pkg::ST_HOLD;
        end
      end
      nss_pkg::ST_SCAN: begin
        if (scan_rsp.done) begin
          state_next = out_free ? nss_pkg::ST_IDLE : nss_pkg::ST_HOLD;
        end
      end
      nss_pkg::ST_HOLD: begin
        if (out_free) begin
          state_next = nss_pkg::ST_IDLE;
        end
      end
      default: state_next = nss_pkg::ST_IDLE;
    endcase
  end

  // Controller outputs
  always_comb begin
    in_stall   = state != nss_pkg::ST_IDLE;
    start_scan = (state == nss_pkg::ST_IDLE) && in_valid && (act == nss_pkg::ACT_CONSUME) &&
                 count_nz;
  end

  // Control state and automaton registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= nss_pkg::ST_IDLE;
      start_state  <= nss_pkg::START_RESET;
      edge_count   <= '0;
      final_mask   <= '0;
      current_mask <= nss_pkg::state_bit(nss_pkg::START_RESET, MAX_STATES);
      out_valid    <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_wr_en) begin
        start_state <= cfg_wr_data;
      end
      if (mem_we) begin
        edge_count <= edge_count + CW'(1);
      end
      final_mask <= final_mask_next;
      if (state == nss_pkg::ST_SCAN && scan_rsp.done) begin
        current_mask <= scan_rsp.next_mask;
      end else begin
        current_mask <= current_mask_next;
      end
      if (res_valid && out_free) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Output and hold payload
  always_ff @(posedge clk) begin
    if (res_valid && out_free) begin
      active_mask <= res_mask;
      accepted    <= res_acc;
      table_full  <= res_full;
    end
    if (res_valid && !out_free) begin
      hold_mask <= res_mask;
      hold_acc  <= res_acc;
      hold_full <= res_full;
    end
  end

  assign scan_req.start    = start_scan;
  assign scan_req.sym      = symbol;
  assign scan_req.cur_mask = current_mask;

  nss_ram #(
    .WIDTH (nss_pkg::EDGE_W),
    .DEPTH (MAX_EDGES)
  ) u_edge_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (edge_count[AW-1:0]),
    .wdata ({source_state, target_state, symbol}),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  nss_scan #(
    .MAX_STATES (MAX_STATES),
    .MAX_EDGES  (MAX_EDGES)
  ) u_scan (
    .clk     (clk),
    .rst     (rst),
    .req     (scan_req),
    .count   (edge_count),
    .rd_en   (mem_re),
    .rd_addr (mem_raddr),
    .rd_data (mem_rdata),
    .rsp     (scan_rsp)
  );

endmodule

`default_nettype wire

/* rtl/nss_ram.sv */
`default_nettype none

module nss_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16,
  localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic             re,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write port, one registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

/* rtl/nss_scan.sv */
`default_nettype none

module nss_scan #(
  parameter int unsigned MAX_STATES = nss_pkg::MAX_STATES_DEF,
  parameter int unsigned MAX_EDGES  = nss_pkg::MAX_EDGES_DEF,
  localparam int unsigned AW = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1,
  localparam int unsigned CW = $clog2(MAX_EDGES + 1)
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire nss_pkg::scan_req_t          req,
  input  wire logic [CW-1:0]               count,
  output logic                             rd_en,
  output logic [AW-1:0]                    rd_addr,
  input  wire logic [nss_pkg::EDGE_W-1:0]  rd_data,
  output nss_pkg::scan_rsp_t               rsp
);

  logic                          issuing;
  logic [CW-1:0]                 k;
  logic                          rvalid;
  logic                          rlast;
  logic                          done;
  logic [nss_pkg::SYM_W-1:0]     sym;
  logic [nss_pkg::MASK_W-1:0]    acc;

  logic                          last_issue;
  logic [nss_pkg::STATE_W-1:0]   e_src;
  logic [nss_pkg::STATE_W-1:0]   e_dst;
  logic [nss_pkg::SYM_W-1:0]     e_sym;
  logic [nss_pkg::MASK_W-1:0]    src_bit;
  logic                          fire;

  assign rd_en      = issuing;
  assign rd_addr    = k[AW-1:0];
  assign last_issue = (k + CW'(1)) == count;

  // Unpack the edge word that came back from memory
  assign e_src   = rd_data[nss_pkg::EDGE_SRC_LSB +: nss_pkg::STATE_W];
  assign e_dst   = rd_data[nss_pkg::EDGE_DST_LSB +: nss_pkg::STATE_W];
  assign e_sym   = rd_data[nss_pkg::EDGE_SYM_LSB +: nss_pkg::SYM_W];
  assign src_bit = nss_pkg::state_bit(e_src, MAX_STATES);
  assign fire    = rvalid && ((req.cur_mask & src_bit) != '0) && (e_sym == sym);

  // Address sweep over the stored edges
  always_ff @(posedge clk) begin
    if (rst) begin
      issuing <= 1'b0;
      rvalid  <= 1'b0;
      rlast   <= 1'b0;
      done    <= 1'b0;
    end else begin
      rvalid <= issuing;
      rlast  <= issuing && last_issue;
      done   <= rvalid && rlast;
      if (req.start) begin
        issuing <= 1'b1;
      end else if (issuing && last_issue) begin
        issuing <= 1'b0;
      end
    end
  end

  // Counter, symbol latch and union accumulator
  always_ff @(posedge clk) begin
    if (req.start) begin
      k   <= '0;
      sym <= req.sym;
      acc <= '0;
    end else begin
      if (issuing) begin
        k <= k + CW'(1);
      end
      if (fire) begin
        acc <= acc | nss_pkg::state_bit(e_dst, MAX_STATES);
      end
    end
  end

  assign rsp.done      = done;
  assign rsp.next_mask = acc;

endmodule

`default_nettype wire

/* bench/tb_nfa_symbol_stepper_top.sv */
`default_nettype none

module tb_nfa_symbol_stepper_top;

  localparam int unsigned N_STATES    = nss_pkg::MAX_STATES_DEF;
  localparam int unsigned N_EDGES     = nss_pkg::MAX_EDGES_DEF;
  localparam int unsigned PHASE_ITEMS = 222;
  localparam int unsigned N_PHASES    = 6;
  // a full edge sweep plus slack
  localparam int unsigned TAIL_CYCLES = 300;

  typedef struct packed {
    logic [nss_pkg::STATE_W-1:0] src;
    logic [nss_pkg::STATE_W-1:0] dst;
    logic [nss_pkg::SYM_W-1:0]   sym;
  } nfa_edge_t;

  typedef struct packed {
    logic [nss_pkg::MASK_W-1:0] mask;
    logic                       acc;
    logic                       full;
  } nfa_result_t;

  // Tracks the automaton and the results it still owes
  class nfa_tracker;
    nfa_edge_t                   edges[N_EDGES];
    int unsigned                 edge_count;
    logic [nss_pkg::MASK_W-1:0]  final_states;
    logic [nss_pkg::MASK_W-1:0]  active;
    logic [nss_pkg::STATE_W-1:0] start;
    nfa_result_t                 owed_results[$];
    int unsigned                 errors;
    int unsigned                 seen;

    function new();
      edge_count   = 0;
      final_states = '0;
      start        = nss_pkg::START_RESET;
      active       = state_mask(nss_pkg::START_RESET);
      errors       = 0;
      seen         = 0;
    endfunction

    // one-hot of a state, empty when out of range
    function logic [nss_pkg::MASK_W-1:0] state_mask(logic [nss_pkg::STATE_W-1:0] s);
      logic [nss_pkg::MASK_W-1:0] m;
      m = '0;
      if (int'(s) < N_STATES) m[s] = 1'b1;
      return m;
    endfunction

    // takes effect at the next end of word
    function void set_start(logic [nss_pkg::STATE_W-1:0] s);
      start = s;
    endfunction

    function int pending();
      return owed_results.size();
    endfunction

    // Advance the automaton by one accepted item
    function void note_item(nss_pkg::action_t act, logic [nss_pkg::STATE_W-1:0] src,
                            logic [nss_pkg::STATE_W-1:0] dst,
                            logic [nss_pkg::SYM_W-1:0] sym);
      nfa_result_t                r;
      logic [nss_pkg::MASK_W-1:0] nxt;
      r = '0;
      case (act)
        nss_pkg::ACT_LOAD: begin
          if (edge_count < N_EDGES) begin
            edges[edge_count] = '{src: src, dst: dst, sym: sym};
            edge_count++;
          end else begin
            r.full = 1'b1;
          end
        end
        nss_pkg::ACT_FINAL: begin
          final_states |= state_mask(src);
        end
        nss_pkg::ACT_CONSUME: begin
          nxt = '0;
          for (int k = 0; k < edge_count; k++) begin
            if ((active & state_mask(edges[k].src)) != '0 && edges[k].sym == sym)
              nxt |= state_mask(edges[k].dst);
          end
          active = nxt;
        end
        default: begin
          r.acc  = (active & final_states) != '0;
          active = state_mask(start);
        end
      endcase
      r.mask = active;
      owed_results = {owed_results, r};
    endfunction

    task report(string msg);
      if (errors < 100) $display("MISMATCH: %s", msg);
      errors++;
    endtask

    // Compare one accepted result with the oldest one owed
    task check_result(logic [nss_pkg::MASK_W-1:0] mask, logic acc, logic full);
      nfa_result_t want;
      seen++;
      if (owed_results.size() == 0) begin
        report($sformatf("result %0d arrived with nothing owed", seen));
        return;
      end
      want = owed_results.pop_front();
      if (mask !== want.mask)
        report($sformatf("result %0d: active_mask %h, want %h", seen, mask, want.mask));
      if (acc !== want.acc)
        report($sformatf("result %0d: accepted %b, want %b", seen, acc, want.acc));
      if (full !== want.full)
        report($sformatf("result %0d: table_full %b, want %b", seen, full, want.full));
    endtask
  endclass

  logic                        clk = 1'b0;
  logic                        rst;
  logic                        cfg_wr_en;
  logic [nss_pkg::STATE_W-1:0] cfg_wr_data;
  logic                        in_valid;
  logic                        in_stall;
  logic [1:0]                  action;
  logic [nss_pkg::STATE_W-1:0] source_state;
  logic [nss_pkg::STATE_W-1:0] target_state;
  logic [nss_pkg::SYM_W-1:0]   symbol;
  logic                        out_valid;
  logic                        out_stall;
  logic [nss_pkg::MASK_W-1:0]  active_mask;
  logic                        accepted;
  logic                        table_full;

  // no idling on either side while set
  logic                        calm = 1'b0;
  int unsigned                 items_sent = 0;
  nfa_tracker                  sb = new();

  nfa_symbol_stepper_top u_dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_wr_data  (cfg_wr_data),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .action       (action),
    .source_state (source_state),
    .target_state (target_state),
    .symbol       (symbol),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .active_mask  (active_mask),
    .accepted     (accepted),
    .table_full   (table_full)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Present one item, hold it through stalls, note it once taken
  task automatic send_item(nss_pkg::action_t act, logic [nss_pkg::STATE_W-1:0] src,
                           logic [nss_pkg::STATE_W-1:0] dst,
                           logic [nss_pkg::SYM_W-1:0] sym);
    while (!calm && $urandom_range(0, 99) < 15) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid     <= 1'b1;
    action       <= act;
    source_state <= src;
    target_state <= dst;
    symbol       <= sym;
    @(posedge clk);
    while (in_stall !== 1'b0) @(posedge clk);
    sb.note_item(act, src, dst, sym);
    items_sent++;
  endtask

  task automatic noise_item();
    send_item(nss_pkg::action_t'($urandom_range(0, 3)), nss_pkg::STATE_W'($urandom()),
              nss_pkg::STATE_W'($urandom()), nss_pkg::SYM_W'($urandom()));
  endtask

  // Drop valid and wait until every owed result is back
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
  endtask

  task automatic write_start(logic [nss_pkg::STATE_W-1:0] s);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= s;
    @(posedge clk);
    sb.set_start(s);
    cfg_wr_en   <= 1'b0;
  endtask

  // A few edges, maybe a final mark, then a short word over a small alphabet
  task automatic random_word();
    int unsigned n_loads;
    int unsigned n_syms;
    n_loads = $urandom_range(0, 2);
    n_syms  = $urandom_range(0, 6);
    repeat (n_loads)
      send_item(nss_pkg::ACT_LOAD, nss_pkg::STATE_W'($urandom_range(0, 31)),
                nss_pkg::STATE_W'($urandom_range(0, 31)),
                nss_pkg::SYM_W'($urandom_range(0, 7)));
    if ($urandom_range(0, 19) == 0)
      send_item(nss_pkg::ACT_FINAL, nss_pkg::STATE_W'($urandom_range(0, 63)),
                nss_pkg::STATE_W'($urandom()), nss_pkg::SYM_W'($urandom()));
    repeat (n_syms) begin
      if ($urandom_range(0, 9) == 0)
        noise_item();
      else if ($urandom_range(0, 15) == 0)
        send_item(nss_pkg::ACT_CONSUME, nss_pkg::STATE_W'($urandom()),
                  nss_pkg::STATE_W'($urandom()), nss_pkg::SYM_W'($urandom()));
      else
        send_item(nss_pkg::ACT_CONSUME, nss_pkg::STATE_W'($urandom()),
                  nss_pkg::STATE_W'($urandom()), nss_pkg::SYM_W'($urandom_range(0, 7)));
    end
    send_item(nss_pkg::ACT_END, nss_pkg::STATE_W'($urandom()),
              nss_pkg::STATE_W'($urandom()), nss_pkg::SYM_W'($urandom()));
  endtask

  // Result side: check on every accepted result, stall at random
  initial begin
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && out_valid === 1'b1 && !out_stall)
        sb.check_result(active_mask, accepted, table_full);
      out_stall <= !calm && ($urandom_range(0, 99) < 15);
    end
  end

  // Stimulus
  initial begin
    logic [nss_pkg::STATE_W-1:0] phase_start[N_PHASES];
    phase_start[0] = 6'd0;
    phase_start[1] = 6'd63;
    phase_start[2] = nss_pkg::STATE_W'($urandom_range(0, 31));
    phase_start[3] = nss_pkg::STATE_W'($urandom_range(0, 63));
    phase_start[4] = 6'd31;
    phase_start[5] = nss_pkg::START_RESET;

    rst          <= 1'b1;
    cfg_wr_en    <= 1'b0;
    cfg_wr_data  <= '0;
    in_valid     <= 1'b0;
    action       <= nss_pkg::ACT_LOAD;
    source_state <= '0;
    target_state <= '0;
    symbol       <= '0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // empty word, no finals yet, then with the start state final
    send_item(nss_pkg::ACT_END, 6'd0, 6'd0, 8'd0);
    send_item(nss_pkg::ACT_FINAL, 6'd1, 6'd0, 8'd0);
    send_item(nss_pkg::ACT_END, 6'd0, 6'd0, 8'd0);
    // symbols with an empty table kill the set, which stays dead
    send_item(nss_pkg::ACT_CONSUME, 6'd0, 6'd0, 8'd0);
    send_item(nss_pkg::ACT_CONSUME, 6'd63, 6'd63, 8'd255);
    send_item(nss_pkg::ACT_END, 6'd0, 6'd0, 8'd0);
    // edges hitting the extremes, several into the start state
    send_item(nss_pkg::ACT_LOAD, 6'd1, 6'd2, 8'h41);
    send_item(nss_pkg::ACT_LOAD, 6'd1, 6'd1, 8'h41);
    send_item(nss_pkg::ACT_LOAD, 6'd2, 6'd1, 8'h41);
    send_item(nss_pkg::ACT_LOAD, 6'd1, 6'd63, 8'hff);
    send_item(nss_pkg::ACT_LOAD, 6'd63, 6'd0, 8'h00);
    send_item(nss_pkg::ACT_LOAD, 6'd0, 6'd63, 8'h41);
    send_item(nss_pkg::ACT_FINAL, 6'd63, 6'd0, 8'd0);
    send_item(nss_pkg::ACT_FINAL, 6'd0, 6'd63, 8'hff);
    send_item(nss_pkg::ACT_CONSUME, 6'd0, 6'd0, 8'h41);
    send_item(nss_pkg::ACT_CONSUME, 6'd0, 6'd0, 8'h41);
    send_item(nss_pkg::ACT_CONSUME, 6'd0, 6'd0, 8'hff);
    send_item(nss_pkg::ACT_CONSUME, 6'd0, 6'd0, 8'h00);
    send_item(nss_pkg::ACT_END, 6'd0, 6'd0, 8'd0);
    // no edge for this symbol: dead set until end of word
    send_item(nss_pkg::ACT_CONSUME, 6'd0, 6'd0, 8'h42);
    send_item(nss_pkg::ACT_CONSUME, 6'd0, 6'd0, 8'h41);
    send_item(nss_pkg::ACT_END, 6'd0, 6'd0, 8'd0);
    // new start state shows up only after the next end of word
    wait_idle();
    write_start(6'd63);
    send_item(nss_pkg::ACT_END, 6'd0, 6'd0, 8'd0);
    send_item(nss_pkg::ACT_CONSUME, 6'd0, 6'd0, 8'h00);
    send_item(nss_pkg::ACT_END, 6'd0, 6'd0, 8'd0);

    // Random phases, one start state each, one phase without idling
    for (int p = 0; p < N_PHASES; p++) begin
      wait_idle();
      write_start(phase_start[p]);
      calm = (p == 2);
      while (items_sent < 25 + (p + 1) * PHASE_ITEMS) begin
        if ($urandom_range(0, 9) == 0)
          noise_item();
        else
          random_word();
      end
    end
    calm = 1'b0;

    wait_idle();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (sb.errors == 0) begin
      $display("tb_nfa_symbol_stepper_top: PASS");
    end else begin
      $display("tb_nfa_symbol_stepper_top: FAIL");
    end
    $finish;
  end

  // Hang guard
  initial begin
    #10_000_000;
    $display("tb_nfa_symbol_stepper_top: FAIL");
    $finish;
  end

endmodule

`default_nettype wire
